// ===== rtl/jkve_pkg.sv =====
// ----------------------------------------------------------------------------
// jkve_pkg
// Shared types, character codes and register indexes of the JSON key/value
// extractor.
// ----------------------------------------------------------------------------
package jkve_pkg;

  // character codes
  localparam logic [7:0] CHR_QUOTE  = 8'h22;
  localparam logic [7:0] CHR_BSLASH = 8'h5C;
  localparam logic [7:0] CHR_COLON  = 8'h3A;
  localparam logic [7:0] CHR_SPACE  = 8'h20;
  localparam logic [7:0] CHR_LF     = 8'h0A;
  localparam logic [7:0] CHR_CR     = 8'h0D;
  localparam logic [7:0] CHR_MINUS  = 8'h2D;
  localparam logic [7:0] CHR_ZERO   = 8'h30;
  localparam logic [7:0] CHR_NINE   = 8'h39;

  // key storage: four 64-bit registers, 32 bytes
  localparam int KEY_REGS      = 4;
  localparam int KEY_BYTES_ALL = 32;

  // configuration register indexes
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_0      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_1      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_2      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_3      = 8'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 8'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_KIND = 8'd5;

  // value kinds
  localparam logic [1:0] KIND_INT  = 2'd0;
  localparam logic [1:0] KIND_BOOL = 2'd1;
  localparam logic [1:0] KIND_STR  = 2'd2;

  // verdict codes
  localparam logic [1:0] VERDICT_FOUND     = 2'd0;
  localparam logic [1:0] VERDICT_NOT_FOUND = 2'd1;
  localparam logic [1:0] VERDICT_BAD       = 2'd2;

  // result item kinds
  localparam logic ITEM_STRING  = 1'b0;
  localparam logic ITEM_VERDICT = 1'b1;

  // integer saturation bounds on the magnitude
  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
  localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic              item_kind;
    logic [7:0]        string_byte;
    logic [1:0]        verdict;
    logic signed [31:0] int_value;
    logic              bool_value;
    logic              last;
  } out_item_t;

  // classified beat between front and back
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
    logic       key_hit;
  } q_item_t;

  typedef struct packed {
    logic [KEY_REGS-1:0][63:0] key;
    logic [5:0]                length;
  } key_cfg_t;

  function automatic logic [7:0] lit_true(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h74; // t
      3'd1:    c = 8'h72; // r
      3'd2:    c = 8'h75; // u
      3'd3:    c = 8'h65; // e
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] lit_false(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h66; // f
      3'd1:    c = 8'h61; // a
      3'd2:    c = 8'h6C; // l
      3'd3:    c = 8'h73; // s
      3'd4:    c = 8'h65; // e
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/jkve_fifo.sv =====
// ----------------------------------------------------------------------------
// jkve_fifo
// Small register queue that decouples the front classifier from the value
// parser.
// ----------------------------------------------------------------------------
module jkve_fifo #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/jkve_front.sv =====
// ----------------------------------------------------------------------------
// jkve_front
// Keeps the window of recent bytes and flags the quote that closes the
// configured key, comparing the whole window in parallel.
// ----------------------------------------------------------------------------
module jkve_front import jkve_pkg::*; #(
  parameter int KEY_MAX_BYTES = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  key_cfg_t key_cfg_i,
  input  logic     accept_i,
  input  in_item_t item_i,
  output q_item_t  item_o
);

  localparam int WIN = KEY_MAX_BYTES + 1;

  logic [7:0] win_q [WIN];
  logic [WIN-1:0] wv_q;
  logic           searching_q;

  // key laid out against the window, refreshed every cycle from the registers
  logic [7:0]     akey_q [WIN];
  logic [7:0]     akey_d [WIN];
  logic [WIN-1:0] care_q, care_d;

  logic [5:0]     len_eff;
  logic [KEY_BYTES_ALL*8-1:0] key_flat;
  logic [WIN-1:0] pos_ok;
  logic           hit;

  assign key_flat = key_cfg_i.key;

  always_comb begin
    len_eff = key_cfg_i.length;
    if (len_eff == 6'd0) begin
      len_eff = 6'd1;
    end
    if (len_eff > 6'(KEY_MAX_BYTES)) begin
      len_eff = 6'(KEY_MAX_BYTES);
    end
  end

  always_comb begin
    for (int j = 0; j < WIN; j++) begin
      logic [5:0] k;
      k = len_eff - 6'(j) - 6'd1;
      if (6'(j) < len_eff) begin
        akey_d[j] = key_flat[k[4:0]*8 +: 8];
        care_d[j] = 1'b1;
      end else if (6'(j) == len_eff) begin
        akey_d[j] = CHR_QUOTE;
        care_d[j] = 1'b1;
      end else begin
        akey_d[j] = 8'h00;
        care_d[j] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < WIN; j++) begin
      akey_q[j] <= akey_d[j];
    end
    care_q <= care_d;
  end

  always_comb begin
    for (int j = 0; j < WIN; j++) begin
      pos_ok[j] = !care_q[j] || (wv_q[j] && (win_q[j] == akey_q[j]));
    end
  end

  assign hit = searching_q && (item_i.text_byte == CHR_QUOTE) && (&pos_ok);

  assign item_o.text_byte   = item_i.text_byte;
  assign item_o.end_of_text = item_i.end_of_text;
  assign item_o.key_hit     = hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wv_q        <= '0;
      searching_q <= 1'b1;
    end else if (accept_i) begin
      if (item_i.end_of_text) begin
        wv_q        <= '0;
        searching_q <= 1'b1;
      end else begin
        wv_q <= {wv_q[WIN-2:0], 1'b1};
        if (hit) begin
          searching_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      win_q[0] <= item_i.text_byte;
      for (int j = 1; j < WIN; j++) begin
        win_q[j] <= win_q[j-1];
      end
    end
  end

endmodule

// ===== rtl/jkve_back.sv =====
// ----------------------------------------------------------------------------
// jkve_back
// Value parser: skips separators, converts integers, matches literals,
// passes string bytes and builds the verdict, into a small result queue.
// ----------------------------------------------------------------------------
module jkve_back import jkve_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic [1:0] value_kind_i,
  input  logic      head_valid_i,
  input  q_item_t   head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam logic [2:0] PH_SEARCH = 3'd0;
  localparam logic [2:0] PH_SKIP   = 3'd1;
  localparam logic [2:0] PH_INT    = 3'd2;
  localparam logic [2:0] PH_BOOL   = 3'd3;
  localparam logic [2:0] PH_STR    = 3'd4;
  localparam logic [2:0] PH_OK     = 3'd5;
  localparam logic [2:0] PH_BAD    = 3'd6;

  localparam int OUT_DEPTH = 4;

  logic [2:0]  phase_q, phase_d;
  logic [31:0] acc_q, acc_d;
  logic        neg_q, neg_d;
  logic [2:0]  idx_q, idx_d;
  logic [1:0]  cand_q, cand_d;
  logic [7:0]  prev_q, prev_d;

  out_item_t   oq_q [OUT_DEPTH];
  logic [1:0]  wr_ptr_q, rd_ptr_q;
  logic [2:0]  cnt_q;
  logic        out_pop;

  logic [7:0]  b;
  logic        is_digit, is_sep;
  logic [35:0] prod;
  logic [31:0] acc_next;
  logic        emit, start, bool_step;
  logic [1:0]  ct;
  logic [1:0]  verdict;
  out_item_t   res_str, res_end, res0;
  logic [1:0]  n_push;

  assign b        = head_i.text_byte;
  assign is_digit = (b >= CHR_ZERO) && (b <= CHR_NINE);
  assign is_sep   = (b == CHR_COLON) || (b == CHR_SPACE) || (b == CHR_LF) || (b == CHR_CR);

  // acc * 10 + digit, saturated on the magnitude
  always_comb begin
    prod = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {32'b0, b[3:0]};
    acc_next = (prod > {4'b0, MAG_LIMIT}) ? MAG_LIMIT : prod[31:0];
  end

  // room for two results keeps the pop decision simple
  assign pop_o = head_valid_i && (cnt_q <= 3'd2);

  always_comb begin
    phase_d   = phase_q;
    acc_d     = acc_q;
    neg_d     = neg_q;
    idx_d     = idx_q;
    cand_d    = cand_q;
    prev_d    = prev_q;
    emit      = 1'b0;
    start     = 1'b0;
    bool_step = 1'b0;
    ct        = cand_q;
    verdict   = VERDICT_BAD;

    unique case (phase_q)
      PH_SEARCH: begin
        if (head_i.key_hit) begin
          phase_d = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (!is_sep) begin
          start = 1'b1;
        end
      end
      PH_INT: begin
        if (is_digit) begin
          acc_d = acc_next;
        end else begin
          phase_d = PH_OK;
        end
      end
      PH_BOOL: bool_step = 1'b1;
      PH_STR: begin
        if (b == CHR_QUOTE && prev_q != CHR_BSLASH) begin
          phase_d = PH_OK;
        end else begin
          prev_d = b;
          emit   = 1'b1;
        end
      end
      default: ;
    endcase

    if (start) begin
      case (value_kind_i)
        KIND_INT: begin
          if (b == CHR_MINUS) begin
            neg_d   = 1'b1;
            phase_d = PH_INT;
          end else if (is_digit) begin
            acc_d   = acc_next;
            phase_d = PH_INT;
          end else begin
            phase_d = PH_BAD;
          end
        end
        KIND_BOOL: bool_step = 1'b1;
        KIND_STR: begin
          if (b == CHR_QUOTE && !head_i.end_of_text) begin
            phase_d = PH_STR;
            prev_d  = CHR_QUOTE;
          end else begin
            phase_d = PH_BAD;
          end
        end
        default: phase_d = PH_BAD;
      endcase
    end

    if (bool_step) begin
      ct = cand_q;
      if (ct[0] && (idx_q >= 3'd4 || lit_true(idx_q) != b)) begin
        ct[0] = 1'b0;
      end
      if (ct[1] && (idx_q >= 3'd5 || lit_false(idx_q) != b)) begin
        ct[1] = 1'b0;
      end
      if (ct == 2'b00) begin
        phase_d = PH_BAD;
        cand_d  = ct;
      end else if (ct[0] && idx_q == 3'd3) begin
        phase_d = PH_OK;
        cand_d  = 2'b01;
      end else if (ct[1] && idx_q == 3'd4) begin
        phase_d = PH_OK;
        cand_d  = 2'b10;
      end else begin
        phase_d = PH_BOOL;
        cand_d  = ct;
        idx_d   = idx_q + 3'd1;
      end
    end

    if (phase_d == PH_SEARCH) begin
      verdict = VERDICT_NOT_FOUND;
    end else if (phase_d == PH_INT || phase_d == PH_STR || phase_d == PH_OK) begin
      verdict = VERDICT_FOUND;
    end

    res_str             = '0;
    res_str.item_kind   = ITEM_STRING;
    res_str.string_byte = b;

    res_end           = '0;
    res_end.item_kind = ITEM_VERDICT;
    res_end.verdict   = verdict;
    res_end.last      = 1'b1;
    if (verdict == VERDICT_FOUND && value_kind_i == KIND_INT) begin
      if (neg_d) begin
        res_end.int_value = 32'(32'd0 - acc_d);
      end else begin
        res_end.int_value = (acc_d > POS_MAX) ? POS_MAX : acc_d;
      end
    end
    if (verdict == VERDICT_FOUND && value_kind_i == KIND_BOOL) begin
      res_end.bool_value = (cand_d == 2'b01);
    end

    res0   = emit ? res_str : res_end;
    n_push = {1'b0, emit} + {1'b0, head_i.end_of_text};

    // every text starts from a clean parser
    if (head_i.end_of_text) begin
      phase_d = PH_SEARCH;
      acc_d   = '0;
      neg_d   = 1'b0;
      idx_d   = '0;
      cand_d  = 2'b11;
      prev_d  = CHR_QUOTE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEARCH;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      idx_q   <= '0;
      cand_q  <= 2'b11;
      prev_q  <= CHR_QUOTE;
    end else if (pop_o) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      neg_q   <= neg_d;
      idx_q   <= idx_d;
      cand_q  <= cand_d;
      prev_q  <= prev_d;
    end
  end

  // result queue
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_item_o  = oq_q[rd_ptr_q];
  assign out_pop     = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (pop_o) begin
        wr_ptr_q <= wr_ptr_q + n_push;
      end
      if (out_pop) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      cnt_q <= cnt_q + (pop_o ? {1'b0, n_push} : 3'd0) - {2'b0, out_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && n_push != 2'd0) begin
      oq_q[wr_ptr_q] <= res0;
    end
    if (pop_o && n_push == 2'd2) begin
      oq_q[wr_ptr_q + 2'd1] <= res_end;
    end
  end

endmodule

// ===== rtl/json_key_value_extractor.sv =====
// ----------------------------------------------------------------------------
// json_key_value_extractor
// Finds a configured key in a JSON byte stream and extracts its value.
// ----------------------------------------------------------------------------
// One text byte is taken per clock cycle unless the input stalls. The front
// compares the byte window against the key in parallel in the cycle the byte
// is accepted and hands the classified byte through a four-entry queue to the
// value parser, which retires one byte per cycle while its four-entry result
// queue has room for two. A byte that both carries a string value byte and ends
// the text yields two results, queued together. After every configuration write
// or reset the input stalls for one cycle while the aligned key copy reloads.
// Configuration registers: index 0..3 key bytes, 4 key length, 5 value kind.
module json_key_value_extractor import jkve_pkg::*; #(
  parameter int KEY_MAX_BYTES = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]          cfg_data_i
);

  localparam int QUEUE_DEPTH = 4;
  localparam int Q_W         = $bits(q_item_t);

  logic [KEY_REGS-1:0][63:0] key_q;
  logic [5:0]                len_q;
  logic [1:0]                kind_q;
  logic                      cfg_reload_q;
  key_cfg_t                  key_cfg;

  logic     accept;
  logic     q_full, q_valid, q_pop;
  q_item_t  front_item, head_item;
  logic [Q_W-1:0] head_bits;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q        <= '0;
      len_q        <= 6'd1;
      kind_q       <= KIND_INT;
      cfg_reload_q <= 1'b1;
    end else begin
      cfg_reload_q <= cfg_valid_i && cfg_ready_o;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i) inside
          CFG_KEY_0, CFG_KEY_1, CFG_KEY_2, CFG_KEY_3: key_q[cfg_index_i[1:0]] <= cfg_data_i;
          CFG_KEY_LENGTH: len_q  <= cfg_data_i[5:0];
          CFG_VALUE_KIND: kind_q <= cfg_data_i[1:0];
          default: ;
        endcase
      end
    end
  end

  assign key_cfg.key    = key_q;
  assign key_cfg.length = len_q;

  assign in_stall_o = q_full || cfg_reload_q;
  assign accept     = in_valid_i && !in_stall_o;

  jkve_front #(
    .KEY_MAX_BYTES(KEY_MAX_BYTES)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .key_cfg_i(key_cfg),
    .accept_i (accept),
    .item_i   (in_item_i),
    .item_o   (front_item)
  );

  jkve_fifo #(
    .WIDTH(Q_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .data_i (front_item),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (head_bits)
  );

  assign head_item = q_item_t'(head_bits);

  jkve_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_kind_i(kind_q),
    .head_valid_i(q_valid),
    .head_i      (head_item),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
